[rtl/core/fra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fra_pkg
// Shared types, codes and defaults of the reference-counted frame allocator.
// ----------------------------------------------------------------------------
package fra_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int FRAMES_DEF      = 1024;
  localparam int PAGE_SHIFT_DEF  = 12;
  localparam int COUNT_WIDTH_DEF = 16;

  // The used bitmap is organized in words of this many frames.
  localparam int WORD_BITS  = 32;
  localparam int WORD_SHIFT = 5;

  // Register reset values.
  localparam logic [19:0] POOL_BASE_RESET   = 20'd0;
  localparam logic [10:0] POOL_FRAMES_RESET = 11'd1024;

  // Register indexes, taken from the word address bit of the bus.
  localparam logic REG_POOL_BASE   = 1'b0;
  localparam logic REG_POOL_FRAMES = 1'b1;

  // Command codes.
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_REF   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_BADADDR   = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] frame_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] alloc_addr;
    logic [15:0] ref_count;
  } rsp_t;

  typedef struct packed {
    logic [19:0] pool_base_page;
    logic [10:0] pool_frames;
  } cfg_t;

  // Position of the lowest set bit of a bitmap word.
  function automatic logic [WORD_SHIFT-1:0] lowest_set(logic [WORD_BITS-1:0] v);
    logic [WORD_SHIFT-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = WORD_SHIFT'(i);
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/fra_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fra_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fra_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/fra_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fra_cfg
// APB register file holding the pool base page and the pool size.
// ----------------------------------------------------------------------------
module fra_cfg
  import fra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Byte offsets within a register are ignored; bit 2 selects the register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_base_page <= POOL_BASE_RESET;
      cfg_q.pool_frames    <= POOL_FRAMES_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_POOL_BASE) begin
        cfg_q.pool_base_page <= pwdata[19:0];
      end else begin
        cfg_q.pool_frames <= pwdata[10:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_POOL_FRAMES) begin
      prdata = {21'd0, cfg_q.pool_frames};
    end else begin
      prdata = {12'd0, cfg_q.pool_base_page};
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/fra_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fra_ctrl
// Sequencer: clearing sweep, bitmap search, count read-modify-write, result.
// ----------------------------------------------------------------------------
module fra_ctrl
  import fra_pkg::*;
#(
  parameter int FRAMES      = FRAMES_DEF,
  parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int FIW         = $clog2(FRAMES),
  parameter int WIW         = 1,
  parameter int WORDS_RAM   = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  req_t                   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rsp_t                   out_data_o,
  output logic                   bm_we_o,
  output logic [WIW-1:0]         bm_waddr_o,
  output logic [WORD_BITS-1:0]   bm_wdata_o,
  output logic                   bm_re_o,
  output logic [WIW-1:0]         bm_raddr_o,
  input  logic [WORD_BITS-1:0]   bm_rdata_i,
  output logic                   cnt_we_o,
  output logic [FIW-1:0]         cnt_waddr_o,
  output logic [COUNT_WIDTH-1:0] cnt_wdata_o,
  output logic                   cnt_re_o,
  output logic [FIW-1:0]         cnt_raddr_o,
  input  logic [COUNT_WIDTH-1:0] cnt_rdata_i
);

  localparam int IDXW = WIW + WORD_SHIFT;
  localparam logic [31:0] PAGE_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_RMW   = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [FIW-1:0]       clr_q, clr_d;
  logic [WIW-1:0]       word_q, word_d;
  logic [1:0]           cmd_q, cmd_d;
  logic [IDXW-1:0]      idx_q, idx_d;
  rsp_t                 res_q, res_d;
  rsp_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic [31:0]          n32, page32, off32, base32, rem32, word_base32;
  logic                 addr_ok;
  logic [WORD_BITS-1:0] avail_mask, free_bits, bit_sel;
  logic [WORD_SHIFT-1:0] free_pos;
  logic [IDXW-1:0]      found_idx;
  logic [COUNT_WIDTH-1:0] new_cnt;

  // Effective pool size and the address check of an incoming beat.
  always_comb begin
    base32 = 32'(cfg_i.pool_base_page);
    if (32'(cfg_i.pool_frames) > 32'(FRAMES)) begin
      n32 = 32'(FRAMES);
    end else begin
      n32 = 32'(cfg_i.pool_frames);
    end
    page32  = in_data_i.frame_addr >> PAGE_SHIFT;
    off32   = page32 - base32;
    addr_ok = ((in_data_i.frame_addr & PAGE_MASK) == 32'd0) &&
              (page32 >= base32) && (off32 < n32);
  end

  // Frames of the current bitmap word that lie inside the pool and are free.
  always_comb begin
    word_base32 = 32'(word_q) << WORD_SHIFT;
    rem32       = n32 - word_base32;
    if (rem32 >= 32'(WORD_BITS)) begin
      avail_mask = '1;
    end else begin
      avail_mask = ~({WORD_BITS{1'b1}} << rem32[WORD_SHIFT-1:0]);
    end
    free_bits = ~bm_rdata_i & avail_mask;
    free_pos  = lowest_set(free_bits);
    found_idx = {word_q, free_pos};
    bit_sel   = {{(WORD_BITS-1){1'b0}}, 1'b1} << idx_q[WORD_SHIFT-1:0];
  end

  // New count of a free or reference request.
  always_comb begin
    new_cnt = cnt_rdata_i;
    if (cmd_q == CMD_FREE) begin
      if (cnt_rdata_i > COUNT_WIDTH'(1)) begin
        new_cnt = cnt_rdata_i - COUNT_WIDTH'(1);
      end else begin
        new_cnt = '0;
      end
    end else if (cnt_rdata_i != {COUNT_WIDTH{1'b1}}) begin
      new_cnt = cnt_rdata_i + COUNT_WIDTH'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    word_d      = word_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    bm_we_o     = 1'b0;
    bm_waddr_o  = word_q;
    bm_wdata_o  = '0;
    bm_re_o     = 1'b0;
    bm_raddr_o  = '0;
    cnt_we_o    = 1'b0;
    cnt_waddr_o = FIW'(idx_q);
    cnt_wdata_o = '0;
    cnt_re_o    = 1'b0;
    cnt_raddr_o = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        cnt_we_o    = 1'b1;
        cnt_waddr_o = clr_q;
        if (32'(clr_q) < 32'(WORDS_RAM)) begin
          bm_we_o    = 1'b1;
          bm_waddr_o = WIW'(clr_q);
        end
        if (clr_q == FIW'(FRAMES - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + FIW'(1);
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d = in_data_i.command;
          idx_d = IDXW'(off32);
          res_d = '{status: ST_BADADDR, alloc_addr: 32'd0, ref_count: 16'd0};
          case (in_data_i.command)
            CMD_ALLOC: begin
              bm_re_o = 1'b1;
              word_d  = '0;
              state_d = S_SCAN;
            end
            CMD_FREE, CMD_REF: begin
              if (addr_ok) begin
                bm_re_o     = 1'b1;
                bm_raddr_o  = WIW'(off32 >> WORD_SHIFT);
                cnt_re_o    = 1'b1;
                cnt_raddr_o = FIW'(off32);
                state_d     = S_RMW;
              end else begin
                state_d = S_RESP;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (free_bits != '0) begin
          bm_we_o     = 1'b1;
          bm_waddr_o  = word_q;
          bm_wdata_o  = bm_rdata_i | ({{(WORD_BITS-1){1'b0}}, 1'b1} << free_pos);
          cnt_we_o    = 1'b1;
          cnt_waddr_o = FIW'(found_idx);
          cnt_wdata_o = COUNT_WIDTH'(1);
          res_d = '{status:     ST_DONE,
                    alloc_addr: (base32 + 32'(found_idx)) << PAGE_SHIFT,
                    ref_count:  16'd1};
          state_d = S_RESP;
        end else if (rem32 <= 32'(WORD_BITS)) begin
          res_d   = '{status: ST_EXHAUSTED, alloc_addr: 32'd0, ref_count: 16'd0};
          state_d = S_RESP;
        end else begin
          word_d     = word_q + WIW'(1);
          bm_re_o    = 1'b1;
          bm_raddr_o = word_q + WIW'(1);
        end
      end
      S_RMW: begin
        cnt_we_o    = 1'b1;
        cnt_waddr_o = FIW'(idx_q);
        cnt_wdata_o = new_cnt;
        if (cmd_q == CMD_FREE && new_cnt == '0) begin
          bm_we_o    = 1'b1;
          bm_waddr_o = idx_q[IDXW-1:WORD_SHIFT];
          bm_wdata_o = bm_rdata_i & ~bit_sel;
        end
        res_d   = '{status: ST_DONE, alloc_addr: 32'd0, ref_count: 16'(new_cnt)};
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/core/refcounted_frame_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_frame_allocator
// Page frame pool with a used bitmap and a reference count per frame.
// ----------------------------------------------------------------------------
//
//   Channel  | Signals                                  | Beat
//   ---------+------------------------------------------+-----------------------
//   request  | in_valid_i, in_ready_o, in_data_i        | command, frame_addr
//   result   | out_valid_o, out_ready_i, out_data_o     | status, alloc_addr,
//            |                                          | ref_count
//   config   | psel, penable, pwrite, paddr, pwdata,    | pool_base_page at 0x0,
//            | prdata, pready                           | pool_frames at 0x4
//
// An allocate reads the bitmap words (one 32-frame word per cycle, lowest
// first) up to the word holding the first free frame or the end of the pool.
// A free or reference runs the count read, the write-back, and the handoff
// to the result register. A rejected address or unknown command goes
// straight to the handoff to the result register.
// After reset a clearing pass writes every count entry and every bitmap word,
// during which no request is accepted.
// A request is accepted while an earlier result still waits in the output
// register; its result is held until that register is taken.
//
// Both stores sit in single-port-write RAMs with a registered read. Requests
// are handled one at a time and every write lands before the next request's
// read, so no forwarding is needed.
// ----------------------------------------------------------------------------
module refcounted_frame_allocator
  import fra_pkg::*;
#(
  parameter int FRAMES      = FRAMES_DEF,
  parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o
);

  // Bitmap geometry: one word per 32 frames, rounded up to a power of two.
  localparam int WORDS     = (FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WORDS_RAM = 1 << WIW;
  localparam int FIW       = $clog2(FRAMES);

  cfg_t                   cfg;
  logic                   bm_we, bm_re;
  logic [WIW-1:0]         bm_waddr, bm_raddr;
  logic [WORD_BITS-1:0]   bm_wdata, bm_rdata;
  logic                   cnt_we, cnt_re;
  logic [FIW-1:0]         cnt_waddr, cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;

  fra_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Used bitmap, one bit per frame, packed into words.
  fra_ram #(
    .W     (WORD_BITS),
    .DEPTH (WORDS_RAM),
    .AW    (WIW)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .re_i    (bm_re),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  // Reference counts, one entry per frame.
  fra_ram #(
    .W     (COUNT_WIDTH),
    .DEPTH (FRAMES),
    .AW    (FIW)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  fra_ctrl #(
    .FRAMES      (FRAMES),
    .PAGE_SHIFT  (PAGE_SHIFT),
    .COUNT_WIDTH (COUNT_WIDTH),
    .FIW         (FIW),
    .WIW         (WIW),
    .WORDS_RAM   (WORDS_RAM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .bm_we_o     (bm_we),
    .bm_waddr_o  (bm_waddr),
    .bm_wdata_o  (bm_wdata),
    .bm_re_o     (bm_re),
    .bm_raddr_o  (bm_raddr),
    .bm_rdata_i  (bm_rdata),
    .cnt_we_o    (cnt_we),
    .cnt_waddr_o (cnt_waddr),
    .cnt_wdata_o (cnt_wdata),
    .cnt_re_o    (cnt_re),
    .cnt_raddr_o (cnt_raddr),
    .cnt_rdata_i (cnt_rdata)
  );

endmodule

[rtl/core/fra_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fra_checker
// Port-level assertions for the frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fra_checker
  import fra_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input req_t        in_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input rsp_t        out_data_o
);

  // A result beat that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // Once reset has been seen at an edge, nothing is offered or taken.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !in_ready_o && !out_valid_o)
    else $error("handshake active during reset");

  // Every accepted request leaves the idle state, so ready drops after an accept.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request accepted while one is in progress");

  // A failed request carries neither an address nor a count.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_DONE |->
      out_data_o.alloc_addr == 32'd0 && out_data_o.ref_count == 16'd0 &&
      (out_data_o.status == ST_EXHAUSTED || out_data_o.status == ST_BADADDR))
    else $error("failed result with nonzero payload or bad status");

endmodule

bind refcounted_frame_allocator fra_checker u_fra_checker (.*);
